// ===== rtl/position_frame_parser_unwrap_assert.svh =====
// ----------------------------------------------------------------------------
// Position frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef POSITION_FRAME_PARSER_UNWRAP_ASSERT_SVH
`define POSITION_FRAME_PARSER_UNWRAP_ASSERT_SVH

// same-cycle implication
`define PFPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfpu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpu_pkg
// Types, constants and the heading conversion for the position frame parser.
// ----------------------------------------------------------------------------
package pfpu_pkg;

    // frame sync bytes
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // payload layout
    localparam int unsigned PAYLOAD_LEN = 24;
    localparam int unsigned IDX_W       = 5;
    localparam int unsigned HEAD_BASE   = 0;
    localparam int unsigned X_BASE      = 12;
    localparam int unsigned Y_BASE      = 16;

    // heading arithmetic, 1/65536 degree units
    localparam int unsigned DELTA_W = 34;
    localparam int unsigned SUM_W   = 48;
    localparam logic signed [DELTA_W-1:0] HALF_TURN = 34'sd11796480;
    localparam logic signed [DELTA_W-1:0] FULL_TURN = 34'sd23592960;

    // float exponent where the mantissa lines up with the fixed point
    localparam logic [7:0] EXP_ALIGN = 8'd134;
    localparam logic [7:0] EXP_SAT   = 8'd142;
    localparam logic [7:0] EXP_SPEC  = 8'hFF;

    localparam logic signed [31:0] FIX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        PH_HUNT_CR  = 3'd0,
        PH_HUNT_LF  = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_TAIL_LF  = 3'd3,
        PH_CLOSE    = 3'd4
    } phase_t;

    // IEEE single -> signed 16.16 fixed, truncating toward zero, saturating
    function automatic logic signed [31:0] float_to_fixed(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [31:0] mant;
        logic [31:0] mag;
        logic [7:0]  lsh;
        logic [7:0]  rsh;
        logic signed [31:0] res;
        neg  = bits[31];
        ex   = bits[30:23];
        frac = bits[22:0];
        mant = {8'd0, (ex != 8'd0), frac};
        mag  = '0;
        lsh  = ex - EXP_ALIGN;
        rsh  = (ex == 8'd0) ? (EXP_ALIGN - 8'd1) : (EXP_ALIGN - ex);
        if (ex == EXP_SPEC) begin
            if (frac != 23'd0)
                res = '0;
            else
                res = neg ? FIX_MIN : FIX_MAX;
        end
        else if (ex > EXP_SAT) begin
            res = neg ? FIX_MIN : FIX_MAX;
        end
        else begin
            if (ex >= EXP_ALIGN)
                mag = mant << lsh[3:0];
            else if (rsh > 8'd31)
                mag = '0;
            else
                mag = mant >> rsh[4:0];
            if (mag[31])
                res = neg ? FIX_MIN : FIX_MAX;
            else
                res = neg ? $signed(32'd0 - mag) : $signed(mag);
        end
        return res;
    endfunction

endpackage

// ===== rtl/position_frame_parser_unwrap.sv =====
// ----------------------------------------------------------------------------
// position_frame_parser_unwrap
// Byte-wise position frame parser with heading unwrap and saturating sum.
// ----------------------------------------------------------------------------
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_ready    | rx_byte
// result   | out_valid / out_ready  | frame_ok, pos_x_bits, pos_y_bits,
//          |                        | heading_sum
//
// One byte per cycle sustained unless a pending result stalls a closing byte;
// each byte is registered at the input before it is parsed; the result is registered.
// Heading conversion and wrap are precomputed from the stored payload while
// the tail bytes arrive; the closing byte only does the 48-bit saturating add.
// Reset clears phase, index, previous heading, heading total and held positions to zero.
// A pending result stalls only the closing byte of the next frame.
// ----------------------------------------------------------------------------
module position_frame_parser_unwrap
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                frame_ok,
    output logic [31:0]         pos_x_bits,
    output logic [31:0]         pos_y_bits,
    output logic signed [47:0]  heading_sum
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    pfpu_pkg::phase_t phase_reg, phase_next;
    logic [pfpu_pkg::IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]  payload_reg [pfpu_pkg::PAYLOAD_LEN];
    logic        store_en;

    // heading state
    logic signed [31:0]                    prev_heading_reg;
    logic signed [pfpu_pkg::SUM_W-1:0]     heading_total_reg;
    logic [31:0]                           held_x_reg;
    logic [31:0]                           held_y_reg;
    logic signed [31:0]                    head_fix_reg;
    logic signed [pfpu_pkg::DELTA_W-1:0]   head_delta_reg;

    // result register
    logic        out_valid_reg;
    logic        out_ok_reg;

    logic        out_free;
    logic        proc_go;
    logic        close_go;
    logic        close_ok;
    logic [pfpu_pkg::IDX_W-1:0] idx_inc;

    logic [31:0] head_word;
    logic signed [pfpu_pkg::DELTA_W-1:0] diff_raw;
    logic signed [pfpu_pkg::DELTA_W-1:0] diff_wrap;
    logic signed [pfpu_pkg::SUM_W:0]     sum_wide;
    logic signed [pfpu_pkg::SUM_W-1:0]   sum_sat;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign proc_go  = in_valid_reg && ((phase_reg != pfpu_pkg::PH_CLOSE) || out_free);
    assign in_ready = !in_valid_reg || proc_go;
    assign close_go = proc_go && (phase_reg == pfpu_pkg::PH_CLOSE);
    assign close_ok = close_go && (in_byte_reg == pfpu_pkg::BYTE_CR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    // frame phase sequencing
    assign idx_inc = byte_index_reg + 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        store_en        = 1'b0;
        if (proc_go) begin
            case (phase_reg)
                pfpu_pkg::PH_HUNT_CR:
                begin
                    phase_next = (in_byte_reg == pfpu_pkg::BYTE_CR) ?
                                 pfpu_pkg::PH_HUNT_LF : pfpu_pkg::PH_HUNT_CR;
                end
                pfpu_pkg::PH_HUNT_LF:
                begin
                    if (in_byte_reg == pfpu_pkg::BYTE_LF) begin
                        byte_index_next = '0;
                        phase_next      = pfpu_pkg::PH_PAYLOAD;
                    end
                    else if (in_byte_reg != pfpu_pkg::BYTE_CR) begin
                        phase_next = pfpu_pkg::PH_HUNT_CR;
                    end
                end
                pfpu_pkg::PH_PAYLOAD:
                begin
                    if (byte_index_reg < pfpu_pkg::IDX_W'(pfpu_pkg::PAYLOAD_LEN)) begin
                        store_en = 1'b1;
                        if (idx_inc >= pfpu_pkg::IDX_W'(pfpu_pkg::PAYLOAD_LEN)) begin
                            byte_index_next = '0;
                            phase_next      = pfpu_pkg::PH_TAIL_LF;
                        end
                        else begin
                            byte_index_next = idx_inc;
                        end
                    end
                    else begin
                        // stray index ends the payload
                        byte_index_next = '0;
                        phase_next      = pfpu_pkg::PH_TAIL_LF;
                    end
                end
                pfpu_pkg::PH_TAIL_LF:
                begin
                    phase_next = (in_byte_reg == pfpu_pkg::BYTE_LF) ?
                                 pfpu_pkg::PH_CLOSE : pfpu_pkg::PH_HUNT_CR;
                end
                pfpu_pkg::PH_CLOSE:
                begin
                    phase_next = pfpu_pkg::PH_HUNT_CR;
                end
                default:
                begin
                    phase_next = pfpu_pkg::PH_HUNT_CR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= pfpu_pkg::PH_HUNT_CR;
            byte_index_reg <= '0;
        end
        else begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
        end
    end

    // payload store
    always_ff @(posedge clk)
    begin
        if (store_en)
            payload_reg[byte_index_reg] <= in_byte_reg;
    end

    // heading precompute: stable long before the closing byte
    assign head_word = {payload_reg[pfpu_pkg::HEAD_BASE + 3], payload_reg[pfpu_pkg::HEAD_BASE + 2],
                        payload_reg[pfpu_pkg::HEAD_BASE + 1], payload_reg[pfpu_pkg::HEAD_BASE]};

    assign diff_raw = pfpu_pkg::DELTA_W'(head_fix_reg) - pfpu_pkg::DELTA_W'(prev_heading_reg);

    always_comb
    begin
        if (diff_raw < -pfpu_pkg::HALF_TURN)
            diff_wrap = diff_raw + pfpu_pkg::FULL_TURN;
        else if (diff_raw > pfpu_pkg::HALF_TURN)
            diff_wrap = diff_raw - pfpu_pkg::FULL_TURN;
        else
            diff_wrap = diff_raw;
    end

    always_ff @(posedge clk)
    begin
        head_fix_reg   <= pfpu_pkg::float_to_fixed(head_word);
        head_delta_reg <= diff_wrap;
    end

    // saturating accumulate
    assign sum_wide = (pfpu_pkg::SUM_W + 1)'(heading_total_reg)
                    + (pfpu_pkg::SUM_W + 1)'(head_delta_reg);

    always_comb
    begin
        if (sum_wide[pfpu_pkg::SUM_W] != sum_wide[pfpu_pkg::SUM_W-1])
            sum_sat = sum_wide[pfpu_pkg::SUM_W] ?
                      {1'b1, {(pfpu_pkg::SUM_W-1){1'b0}}} :
                      {1'b0, {(pfpu_pkg::SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[pfpu_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_heading_reg  <= '0;
            heading_total_reg <= '0;
            held_x_reg        <= '0;
            held_y_reg        <= '0;
        end
        else if (close_ok) begin
            prev_heading_reg  <= head_fix_reg;
            heading_total_reg <= sum_sat;
            held_x_reg <= {payload_reg[pfpu_pkg::X_BASE + 3], payload_reg[pfpu_pkg::X_BASE + 2],
                           payload_reg[pfpu_pkg::X_BASE + 1], payload_reg[pfpu_pkg::X_BASE]};
            held_y_reg <= {payload_reg[pfpu_pkg::Y_BASE + 3], payload_reg[pfpu_pkg::Y_BASE + 2],
                           payload_reg[pfpu_pkg::Y_BASE + 1], payload_reg[pfpu_pkg::Y_BASE]};
        end
    end

    // result register; held values change only when a new result loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (close_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (close_go)
            out_ok_reg <= close_ok;
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = out_ok_reg;
    assign pos_x_bits  = held_x_reg;
    assign pos_y_bits  = held_y_reg;
    assign heading_sum = heading_total_reg;

    // checks
`include "position_frame_parser_unwrap_assert.svh"

    `PFPU_ASSERT_NOW(a_index_range, phase_reg == pfpu_pkg::PH_PAYLOAD,
        byte_index_reg < pfpu_pkg::IDX_W'(pfpu_pkg::PAYLOAD_LEN), "payload index out of range")
    `PFPU_ASSERT_NOW(a_close_room, close_go, out_free, "result loaded over a pending one")
    `PFPU_ASSERT_NEXT(a_prev_follows, close_ok, prev_heading_reg == $past(head_fix_reg),
        "previous heading not taken from converted value")
    `PFPU_ASSERT_NEXT(a_bad_hold, close_go && !close_ok,
        $stable(heading_total_reg) && !out_ok_reg, "bad closing byte changed held values")
    `PFPU_ASSERT_NEXT(a_in_hold, in_valid_reg && !proc_go,
        in_valid_reg && $stable(in_byte_reg), "stalled input byte lost")

endmodule
